// ----- rtl/core/brmq_pkg.sv -----
// Shared constants, types and status codes for the bitmap multilevel ready queue.
// No dependencies; the pick, store and queue modules and the bench import this package.
`timescale 1ns / 1ps

package brmq_pkg;

    localparam int NUM_LEVELS = 32;
    localparam int RING_SIZE  = 16;
    localparam int ITEM_WIDTH = 32;

    localparam int LVL_W  = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
    localparam int PTR_W  = $clog2(RING_SIZE);
    localparam int ADDR_W = $clog2(NUM_LEVELS * RING_SIZE);

    localparam logic MODE_PUT = 1'b0;
    localparam logic MODE_GET = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // Outcome of the level search for a get
    typedef struct packed {
        logic             found;
        logic [LVL_W-1:0] level;
    } pick_t;

endpackage

// ----- rtl/core/brmq_if.sv -----
// Request and response channel interfaces of the ready queue.
// No dependencies; payload widths match the brmq_pkg sizes.
`timescale 1ns / 1ps

interface brmq_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [31:0] item;
    logic [4:0]  priority_req;
    logic [4:0]  floor_level;

    modport source (output valid, output mode, output item, output priority_req,
                    output floor_level, input ready);
    modport sink   (input valid, input mode, input item, input priority_req,
                    input floor_level, output ready);
endinterface

interface brmq_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] item_out;

    modport source (output valid, output status, output item_out, input ready);
    modport sink   (input valid, input status, input item_out, output ready);
endinterface

// ----- rtl/core/brmq_pick.sv -----
// Level search: most urgent occupied level at or above the floor level.
// Depends on brmq_pkg.
`timescale 1ns / 1ps

module brmq_pick
    import brmq_pkg::*;
(
    input  logic [NUM_LEVELS-1:0] occupied,
    input  logic [4:0]            floor_lvl,
    output pick_t                 pick
);

    always_comb
    begin
        pick.found = 1'b0;
        pick.level = '0;
        // scan from the least urgent end so the most urgent hit wins
        for (int i = NUM_LEVELS - 1; i >= 0; i--)
        begin
            if (occupied[i] && (i >= int'(floor_lvl)))
            begin
                pick.found = 1'b1;
                pick.level = LVL_W'(i);
            end
        end
    end

endmodule

// ----- rtl/core/brmq_ram.sv -----
// Item store: one write port, one registered read port, no reset on contents.
// Depends on brmq_pkg for sizes.
`timescale 1ns / 1ps

module brmq_ram
    import brmq_pkg::*;
(
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [ADDR_W-1:0]     wr_addr,
    input  logic [ITEM_WIDTH-1:0] wr_data,
    input  logic                  rd_en,
    input  logic [ADDR_W-1:0]     rd_addr,
    output logic [ITEM_WIDTH-1:0] rd_data
);

    logic [ITEM_WIDTH-1:0] mem [NUM_LEVELS * RING_SIZE];
    logic [ITEM_WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/bitmap_multilevel_ready_queue.sv -----
// Ready queue with one ring FIFO per priority level and an occupancy bitmap.
// Depends on brmq_pkg, brmq_if, brmq_pick and brmq_ram.
`timescale 1ns / 1ps

// The block takes one request item per cycle while the response side keeps up, and
// returns one response item per request. A request is held in an input
// register; from there the level search, the full check and the
// pointer, count and bitmap updates are done, and the item store is written
// (put) or read at the head of the chosen level (get). The store's read port
// is registered at the same edge as the result register, so the read item and
// its status reach the response together. A stalled response holds the whole
// pipe, so at most one request waits behind it. Each level keeps at most
// RING_SIZE-1 items; status is ok, full on put, or empty on get.
module bitmap_multilevel_ready_queue
    import brmq_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    brmq_in_if.sink        req,
    brmq_out_if.source     rsp
);

    localparam int CNT_MAX = RING_SIZE - 1;

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        r = (p == PTR_W'(RING_SIZE - 1)) ? '0 : p + PTR_W'(1);
        return r;
    endfunction

    // input register
    logic        s1_valid_reg;
    logic        s1_mode_reg;
    logic [31:0] s1_item_reg;
    logic [4:0]  s1_prio_reg;
    logic [4:0]  s1_floor_reg;

    // per-level queue state
    logic [PTR_W-1:0]      head_ptr_reg    [NUM_LEVELS];
    logic [PTR_W-1:0]      tail_ptr_reg    [NUM_LEVELS];
    logic [PTR_W-1:0]      level_count_reg [NUM_LEVELS];
    logic [NUM_LEVELS-1:0] occupied_map_reg;
    logic [NUM_LEVELS-1:0] occupied_map_next;

    // result register
    logic    s2_valid_reg;
    status_t s2_status_reg;
    status_t s2_status_next;
    logic    s2_get_ok_reg;

    logic                  advance;
    pick_t                 pick;
    logic [LVL_W-1:0]      put_lvl;
    logic                  put_in_range;
    logic                  put_ok;
    logic                  do_put;
    logic                  do_get;
    logic [ADDR_W-1:0]     wr_addr;
    logic [ADDR_W-1:0]     rd_addr;
    logic [ITEM_WIDTH-1:0] rd_data;

    assign advance   = s1_valid_reg && (!s2_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            s1_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            s1_mode_reg  <= req.mode;
            s1_item_reg  <= req.item;
            s1_prio_reg  <= req.priority_req;
            s1_floor_reg <= req.floor_level;
        end
    end

    brmq_pick u_pick (
        .occupied  (occupied_map_reg),
        .floor_lvl (s1_floor_reg),
        .pick      (pick)
    );

    assign put_lvl      = s1_prio_reg[LVL_W-1:0];
    assign put_in_range = ({1'b0, s1_prio_reg} < 6'(NUM_LEVELS));
    assign put_ok       = put_in_range && (level_count_reg[put_lvl] < PTR_W'(CNT_MAX));
    assign do_put       = advance && (s1_mode_reg == MODE_PUT) && put_ok;
    assign do_get       = advance && (s1_mode_reg == MODE_GET) && pick.found;

    assign wr_addr = ADDR_W'(put_lvl) * ADDR_W'(RING_SIZE) + ADDR_W'(tail_ptr_reg[put_lvl]);
    assign rd_addr = ADDR_W'(pick.level) * ADDR_W'(RING_SIZE)
                   + ADDR_W'(head_ptr_reg[pick.level]);

    brmq_ram u_ram (
        .clk     (clk),
        .wr_en   (do_put),
        .wr_addr (wr_addr),
        .wr_data (ITEM_WIDTH'(s1_item_reg)),
        .rd_en   (do_get),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        occupied_map_next = occupied_map_reg;
        if (do_put)
        begin
            occupied_map_next[put_lvl] = 1'b1;
        end
        // drop the bit as the last item leaves
        if (do_get && (level_count_reg[pick.level] == PTR_W'(1)))
        begin
            occupied_map_next[pick.level] = 1'b0;
        end
    end

    always_comb
    begin
        if (s1_mode_reg == MODE_PUT)
        begin
            s2_status_next = put_ok ? ST_OK : ST_FULL;
        end
        else
        begin
            s2_status_next = pick.found ? ST_OK : ST_EMPTY;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LEVELS; i++)
            begin
                head_ptr_reg[i]    <= '0;
                tail_ptr_reg[i]    <= '0;
                level_count_reg[i] <= '0;
            end
            occupied_map_reg <= '0;
        end
        else
        begin
            occupied_map_reg <= occupied_map_next;
            if (do_put)
            begin
                tail_ptr_reg[put_lvl]    <= ring_next(tail_ptr_reg[put_lvl]);
                level_count_reg[put_lvl] <= level_count_reg[put_lvl] + PTR_W'(1);
            end
            if (do_get)
            begin
                head_ptr_reg[pick.level]    <= ring_next(head_ptr_reg[pick.level]);
                level_count_reg[pick.level] <= level_count_reg[pick.level] - PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            s2_status_reg <= ST_OK;
            s2_get_ok_reg <= 1'b0;
        end
        else if (!s2_valid_reg || rsp.ready)
        begin
            s2_valid_reg <= s1_valid_reg;
            if (advance)
            begin
                s2_status_reg <= s2_status_next;
                s2_get_ok_reg <= (s1_mode_reg == MODE_GET) && pick.found;
            end
        end
    end

    assign rsp.valid    = s2_valid_reg;
    assign rsp.status   = s2_status_reg;
    assign rsp.item_out = s2_get_ok_reg ? 32'(rd_data) : 32'd0;

    // consistency terms for the checks below
    logic [NUM_LEVELS-1:0] nonempty_vec;
    logic                  overfull;
    logic                  ptr_mismatch;

    always_comb
    begin
        logic [PTR_W:0] span;
        overfull     = 1'b0;
        ptr_mismatch = 1'b0;
        for (int i = 0; i < NUM_LEVELS; i++)
        begin
            nonempty_vec[i] = (level_count_reg[i] != '0);
            if (level_count_reg[i] > PTR_W'(CNT_MAX))
            begin
                overfull = 1'b1;
            end
            if (tail_ptr_reg[i] >= head_ptr_reg[i])
            begin
                span = {1'b0, tail_ptr_reg[i]} - {1'b0, head_ptr_reg[i]};
            end
            else
            begin
                span = {1'b0, tail_ptr_reg[i]} + (PTR_W+1)'(RING_SIZE)
                     - {1'b0, head_ptr_reg[i]};
            end
            if (span != {1'b0, level_count_reg[i]})
            begin
                ptr_mismatch = 1'b1;
            end
        end
    end

    a_map_matches_counts: assert property (@(posedge clk) disable iff (!rst_n)
        occupied_map_reg == nonempty_vec)
        else $error("occupancy bitmap disagrees with level counts");

    a_ptrs_match_counts: assert property (@(posedge clk) disable iff (!rst_n)
        !ptr_mismatch)
        else $error("ring pointers disagree with level count");

    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        !overfull)
        else $error("level holds more than RING_SIZE-1 items");

    a_advance_fills_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> s2_valid_reg)
        else $error("advanced item did not reach the result register");

    a_get_ok_status: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && s2_get_ok_reg |-> s2_status_reg == ST_OK)
        else $error("successful get carries a non-ok status");

endmodule

// ----- bench/tb_top.sv -----
// Self-checking bench for bitmap_multilevel_ready_queue: directed and random puts and gets.
// Depends on brmq_pkg, brmq_if and the queue RTL; holds its own copy of the level rings.
`timescale 1ns / 1ps

module tb_top;
    import brmq_pkg::*;

    typedef struct {
        status_t     status;
        logic [31:0] item_out;
    } queue_rsp_t;

    logic clk;
    logic rst_n;

    brmq_in_if  req_if ();
    brmq_out_if rsp_if ();

    bitmap_multilevel_ready_queue uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // Shadow copy of the level rings and occupancy bitmap
    logic [ITEM_WIDTH-1:0] lvl_store [NUM_LEVELS][RING_SIZE];
    int                    lvl_head  [NUM_LEVELS] = '{default: 0};
    int                    lvl_tail  [NUM_LEVELS] = '{default: 0};
    int                    lvl_fill  [NUM_LEVELS] = '{default: 0};
    logic [NUM_LEVELS-1:0] lvl_map = '0;

    queue_rsp_t pending_rsp [$];
    int         mismatches = 0;
    bit         no_idle = 1'b0;
    int         rsp_hold_cycles = 0;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #2ms;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic int ring_advance(input int p);
        return (p + 1 >= RING_SIZE) ? 0 : p + 1;
    endfunction

    // Apply one request to the shadow rings and return the response it should give
    function automatic queue_rsp_t queue_apply(input logic m, input logic [31:0] itm,
                                               input logic [4:0] prio,
                                               input logic [4:0] floor_lvl);
        queue_rsp_t r;
        int         lvl;
        bit         hit;
        r.status   = ST_OK;
        r.item_out = '0;
        if (m == MODE_PUT) begin
            lvl = int'(prio);
            if (lvl >= NUM_LEVELS || lvl_fill[lvl] >= RING_SIZE - 1)
                r.status = ST_FULL;
            else
            begin
                lvl_store[lvl][lvl_tail[lvl]] = itm[ITEM_WIDTH-1:0];
                lvl_tail[lvl] = ring_advance(lvl_tail[lvl]);
                lvl_fill[lvl]++;
                lvl_map[lvl] = 1'b1;
            end
        end
        else
        begin
            hit = 1'b0;
            lvl = int'(floor_lvl);
            while (!hit && lvl < NUM_LEVELS)
            begin
                if (lvl_map[lvl])
                    hit = 1'b1;
                else
                    lvl++;
            end
            if (!hit || lvl_fill[lvl] == 0)
                r.status = ST_EMPTY;
            else
            begin
                r.item_out = lvl_store[lvl][lvl_head[lvl]];
                lvl_head[lvl] = ring_advance(lvl_head[lvl]);
                lvl_fill[lvl]--;
                // clear the bit as soon as the level empties
                if (lvl_fill[lvl] == 0)
                    lvl_map[lvl] = 1'b0;
            end
        end
        return r;
    endfunction

    // Called at a rising edge; returns at the edge where the item is taken
    task automatic send_req(input logic m, input logic [31:0] itm, input logic [4:0] prio,
                            input logic [4:0] floor_lvl);
        // idle at random before the request, with odds of 16 in a hundred per draw
        while (!no_idle && $urandom_range(99) < 16) begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid        <= 1'b1;
        req_if.mode         <= m;
        req_if.item         <= itm;
        req_if.priority_req <= prio;
        req_if.floor_level  <= floor_lvl;
        do @(posedge clk); while (!req_if.ready);
        pending_rsp.push_back(queue_apply(m, itm, prio, floor_lvl));
    endtask

    // Response side: random stalls, plus long hold-offs on request
    initial begin
        int hold_left;
        hold_left = 0;
        rsp_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_hold_cycles != 0) begin
                hold_left = rsp_hold_cycles;
                rsp_hold_cycles = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end
            else
                rsp_if.ready <= no_idle || ($urandom_range(99) >= 16);
        end
    end

    always @(posedge clk)
    begin
        queue_rsp_t exp_rsp;
        if (rst_n && rsp_if.valid && rsp_if.ready) begin
            if (pending_rsp.size() == 0) begin
                $display("%0t ERROR unexpected response: expected none got status %0d item %h",
                         $time, rsp_if.status, rsp_if.item_out);
                mismatches++;
            end
            else
            begin
                exp_rsp = pending_rsp.pop_front();
                if (rsp_if.status !== exp_rsp.status) begin
                    $display("%0t ERROR status: expected %0d got %0d",
                             $time, exp_rsp.status, rsp_if.status);
                    mismatches++;
                end
                if (rsp_if.item_out !== exp_rsp.item_out) begin
                    $display("%0t ERROR item_out: expected %h got %h",
                             $time, exp_rsp.item_out, rsp_if.item_out);
                    mismatches++;
                end
            end
        end
    end

    task automatic test_directed();
        send_req(MODE_PUT, 32'hFFFF_FFFF, 5'd0, 5'd31);
        send_req(MODE_PUT, 32'h0000_0001, 5'd31, 5'd0);
        // zero item still counts as held
        send_req(MODE_PUT, 32'h0000_0000, 5'd31, 5'd0);
        send_req(MODE_GET, 32'h0, 5'd0, 5'd31);
        send_req(MODE_GET, 32'hFFFF_FFFF, 5'd31, 5'd0);
        send_req(MODE_GET, 32'h0, 5'd0, 5'd1);
        send_req(MODE_GET, 32'h0, 5'd0, 5'd0);
        send_req(MODE_GET, 32'h0, 5'd0, 5'd31);
        // floor above one level must skip it
        send_req(MODE_PUT, 32'hA5A5_A5A5, 5'd5, 5'd0);
        send_req(MODE_PUT, 32'h5A5A_5A5A, 5'd20, 5'd0);
        send_req(MODE_GET, 32'h0, 5'd0, 5'd6);
        send_req(MODE_GET, 32'h0, 5'd0, 5'd6);
        send_req(MODE_GET, 32'h0, 5'd0, 5'd0);
    endtask

    task automatic test_level_full();
        int k;
        for (k = 0; k < RING_SIZE; k++)
            send_req(MODE_PUT, $urandom(), 5'd9, 5'($urandom_range(31)));
        send_req(MODE_GET, $urandom(), 5'($urandom_range(31)), 5'd9);
        send_req(MODE_PUT, $urandom(), 5'd9, 5'($urandom_range(31)));
    endtask

    task automatic test_random_traffic(input int n_items);
        int          k;
        int          j;
        int          put_pct;
        int          hot [4];
        logic        m;
        logic [4:0]  prio;
        logic [4:0]  floor_lvl;
        logic [31:0] itm;
        for (k = 0; k < n_items; k++)
        begin
            // new hot levels and put/get balance every hundred items
            if (k % 100 == 0) begin
                for (j = 0; j < 4; j++)
                    hot[j] = $urandom_range(NUM_LEVELS - 1);
                put_pct = $urandom_range(30, 75);
            end
            m    = ($urandom_range(99) < put_pct) ? MODE_PUT : MODE_GET;
            prio = ($urandom_range(99) < 75) ? 5'(hot[$urandom_range(3)])
                                             : 5'($urandom_range(31));
            case ($urandom_range(2))
                0: floor_lvl = 5'd0;
                1: floor_lvl = 5'(hot[$urandom_range(3)]);
                default: floor_lvl = 5'($urandom_range(31));
            endcase
            itm = $urandom();
            if (itm == 32'h0)
                itm = 32'h1;
            send_req(m, itm, prio, floor_lvl);
        end
    endtask

    task automatic test_backpressure();
        rsp_hold_cycles = 120;
        no_idle = 1'b1;
        test_random_traffic(40);
        no_idle = 1'b0;
    endtask

    task automatic test_no_idle_stretch();
        no_idle = 1'b1;
        test_random_traffic(200);
        no_idle = 1'b0;
    endtask

    initial begin
        int drain_wait;
        rst_n = 1'b0;
        req_if.valid        <= 1'b0;
        req_if.mode         <= MODE_PUT;
        req_if.item         <= '0;
        req_if.priority_req <= '0;
        req_if.floor_level  <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_level_full();
        test_random_traffic(400);
        test_backpressure();
        test_no_idle_stretch();
        test_random_traffic(480);

        req_if.valid <= 1'b0;
        drain_wait = 0;
        while (pending_rsp.size() != 0 && drain_wait < 5000)
        begin
            @(posedge clk);
            drain_wait++;
        end
        repeat (8) @(posedge clk);
        if (pending_rsp.size() != 0) begin
            $display("%0t ERROR responses missing: expected %0d more got 0",
                     $time, pending_rsp.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
